@@ rtl/dual_stack_shared_store_core_defines.svh @@
// Assertion macros for the dual stack block.
// Used by the top level only; expects clk and rst in scope.
`ifndef DUAL_STACK_SHARED_STORE_CORE_DEFINES_SVH
`define DUAL_STACK_SHARED_STORE_CORE_DEFINES_SVH

// condition must hold at every edge out of reset
`define DSS_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define DSS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/dss_pkg.sv @@
// Shared types and constants for the dual stack block.
// No dependencies; imported by the interfaces and every module.
package dss_pkg;

  localparam int WORD_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int Q_DEPTH  = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [KIND_W-1:0]        kind_t;
  typedef logic [STATUS_W-1:0]      status_t;

  // request codes on the input channel
  localparam kind_t KIND_PUSH_A = 3'd0;
  localparam kind_t KIND_PUSH_B = 3'd1;
  localparam kind_t KIND_POP_A  = 3'd2;
  localparam kind_t KIND_POP_B  = 3'd3;
  localparam kind_t KIND_PEEK_A = 3'd4;
  localparam kind_t KIND_PEEK_B = 3'd5;

  // response status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;

  localparam word_t WORD_ONES = '1;
  localparam word_t WORD_ZERO = '0;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_NOP
  } op_e;

  // classified request held in the queue
  typedef struct packed {
    op_e   op;
    logic  sel_b;
    word_t value;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    BK_RUN,
    BK_READ
  } bk_state_e;

endpackage

@@ rtl/dss_if.sv @@
// Handshake channels of the dual stack block: request and response.
// Depends on dss_pkg for field types.
interface dss_req_if
  import dss_pkg::*;
  ();
  logic  valid;
  logic  ready;
  kind_t kind;
  word_t push_value;

  modport source (output valid, kind, push_value, input ready);
  modport sink   (input valid, kind, push_value, output ready);
endinterface

interface dss_rsp_if
  import dss_pkg::*;
  ();
  logic    valid;
  logic    ready;
  word_t   read_value;
  status_t status;
  logic    a_empty;
  logic    b_empty;

  modport source (output valid, read_value, status, a_empty, b_empty, input ready);
  modport sink   (input valid, read_value, status, a_empty, b_empty, output ready);
endinterface

@@ rtl/dss_front.sv @@
// Front end: takes request beats and classifies them into queue entries.
// Depends on dss_pkg and dss_req_if.
module dss_front
  import dss_pkg::*;
(
  dss_req_if.sink  req,
  input  q_stat_t  q_stat,
  output logic     enq_valid,
  output op_t      enq_op
);

  // take a beat whenever the queue has room
  assign req.ready = !q_stat.full;
  assign enq_valid = req.valid && !q_stat.full;

  // decode the request code into operation and stack select
  always_comb begin
    enq_op.value = req.push_value;
    enq_op.sel_b = 1'b0;
    unique case (req.kind) inside
      KIND_PUSH_A: enq_op.op = OP_PUSH;
      KIND_PUSH_B: begin
        enq_op.op    = OP_PUSH;
        enq_op.sel_b = 1'b1;
      end
      KIND_POP_A: enq_op.op = OP_POP;
      KIND_POP_B: begin
        enq_op.op    = OP_POP;
        enq_op.sel_b = 1'b1;
      end
      KIND_PEEK_A: enq_op.op = OP_PEEK;
      KIND_PEEK_B: begin
        enq_op.op    = OP_PEEK;
        enq_op.sel_b = 1'b1;
      end
      default: enq_op.op = OP_NOP;
    endcase
  end

endmodule

@@ rtl/dss_queue.sv @@
// Short queue between the front end and the stack engine.
// Depends on dss_pkg.
module dss_queue
  import dss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    enq_valid,
  input  op_t     enq_op,
  output logic    deq_valid,
  output op_t     deq_op,
  input  logic    deq_ready,
  output q_stat_t stat
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  op_t              slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_enq;
  logic             do_deq;

  assign stat.full  = (count == CNT_W'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign do_enq     = enq_valid && !stat.full;
  assign do_deq     = deq_ready && !stat.empty;
  assign deq_valid  = !stat.empty;
  assign deq_op     = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_enq) wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_deq) rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_enq && !do_deq)      count <= count + CNT_W'(1);
      else if (do_deq && !do_enq) count <= count - CNT_W'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_enq) slots[wr_ptr] <= enq_op;
  end

endmodule

@@ rtl/dss_back.sv @@
// Stack engine: holds both stack counts and the shared store, builds responses.
// Depends on dss_pkg and dss_rsp_if.
module dss_back
  import dss_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     deq_valid,
  input  op_t      deq_op,
  output logic     deq_ready,
  dss_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

  bk_state_e      state;
  bk_state_e      state_next;
  logic [CW-1:0]  a_count;
  logic [CW-1:0]  b_count;
  logic [CW-1:0]  a_next;
  logic [CW-1:0]  b_next;
  word_t          store [DEPTH];
  word_t          rd_data;
  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [CW:0]    used;
  logic [CW:0]    b_push_ix;
  logic [CW:0]    b_top_ix;
  logic [CW-1:0]  a_top_ix;
  logic           full;
  logic           sel_empty;
  logic           slot_free;
  logic           take;
  logic           load_imm;
  logic           load_rd;
  word_t          imm_value;
  status_t        imm_status;
  logic           rsp_valid;
  word_t          rsp_value;
  status_t        rsp_status;
  logic           rsp_a_empty;
  logic           rsp_b_empty;

  // index arithmetic for both stack tops
  assign used      = {1'b0, a_count} + {1'b0, b_count};
  assign full      = (used >= DEPTH_W);
  assign b_push_ix = DEPTH_W - {1'b0, b_count} - (CW + 1)'(1);
  assign b_top_ix  = DEPTH_W - {1'b0, b_count};
  assign a_top_ix  = a_count - CW'(1);
  assign sel_empty = deq_op.sel_b ? (b_count == '0) : (a_count == '0);

  // the response slot is free once the current beat leaves
  assign slot_free = !rsp_valid || rsp.ready;
  assign deq_ready = (state == BK_RUN) && slot_free;
  assign take      = deq_valid && deq_ready;

  // next state, count updates and store access
  always_comb begin
    state_next = state;
    a_next     = a_count;
    b_next     = b_count;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    wr_addr    = deq_op.sel_b ? b_push_ix[AW-1:0] : a_count[AW-1:0];
    rd_addr    = deq_op.sel_b ? b_top_ix[AW-1:0] : a_top_ix[AW-1:0];
    imm_value  = WORD_ZERO;
    imm_status = ST_OK;
    load_imm   = 1'b0;
    if (take) begin
      unique case (deq_op.op) inside
        OP_PUSH: begin
          load_imm = 1'b1;
          if (full) begin
            imm_status = ST_OVERFLOW;
          end else begin
            mem_we = 1'b1;
            if (deq_op.sel_b) b_next = b_count + CW'(1);
            else              a_next = a_count + CW'(1);
          end
        end
        OP_POP, OP_PEEK: begin
          if (sel_empty) begin
            load_imm   = 1'b1;
            imm_value  = WORD_ONES;
            imm_status = ST_EMPTY;
          end else begin
            mem_re     = 1'b1;
            state_next = BK_READ;
            if (deq_op.op == OP_POP) begin
              if (deq_op.sel_b) b_next = b_count - CW'(1);
              else              a_next = a_count - CW'(1);
            end
          end
        end
        default: load_imm = 1'b1;
      endcase
    end else if (state == BK_READ) begin
      state_next = BK_RUN;
    end
  end

  assign load_rd = (state == BK_READ);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      a_count   <= '0;
      b_count   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      a_count <= a_next;
      b_count <= b_next;
      if (load_imm || load_rd) rsp_valid <= 1'b1;
      else if (rsp.ready)      rsp_valid <= 1'b0;
    end
  end

  // shared store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) store[wr_addr] <= deq_op.value;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= store[rd_addr];
  end

  // response register; flags reflect counts after the step
  always_ff @(posedge clk) begin
    if (load_imm) begin
      rsp_value   <= imm_value;
      rsp_status  <= imm_status;
      rsp_a_empty <= (a_next == '0);
      rsp_b_empty <= (b_next == '0);
    end else if (load_rd) begin
      rsp_value   <= rd_data;
      rsp_status  <= ST_OK;
      rsp_a_empty <= (a_count == '0);
      rsp_b_empty <= (b_count == '0);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.read_value = rsp_value;
  assign rsp.status     = rsp_status;
  assign rsp.a_empty    = rsp_a_empty;
  assign rsp.b_empty    = rsp_b_empty;

endmodule

@@ rtl/dual_stack_shared_store_core.sv @@
// Two stacks in one shared store: stack A grows up from entry 0, stack B down
// from entry DEPTH-1.
// Channels: req carries kind (push/pop/peek on A or B) and push_value; rsp carries
// read_value, status (ok, overflow, empty) and an empty flag for each stack.
// Every accepted request yields exactly one response beat, in request order.
// A push, a failed pop/peek or an unused kind passes through the queue, then
// the response register; a successful pop or peek also passes through the
// registered read of the store before the response register.
// Pushes and failures are taken one request per cycle while rsp is ready; a
// successful pop or peek holds the stack engine for the store's registered read.
// A 2-entry queue separates the front end from the engine, so req keeps being
// taken while the engine is busy or a response waits.
// Reset empties both stacks and the queue; store contents are left as they are.
// When rsp stalls the response is held, the engine stops, and once the queue
// fills req.ready drops.
// Depends on dss_pkg, dss_if, dss_front, dss_queue, dss_back and the defines.
`include "dual_stack_shared_store_core_defines.svh"

module dual_stack_shared_store_core
  import dss_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  dss_req_if.sink   req,
  dss_rsp_if.source rsp
);

  logic    enq_valid;
  op_t     enq_op;
  logic    deq_valid;
  op_t     deq_op;
  logic    deq_ready;
  q_stat_t q_stat;

  dss_front u_front (
    .req       (req),
    .q_stat    (q_stat),
    .enq_valid (enq_valid),
    .enq_op    (enq_op)
  );

  dss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq_valid (enq_valid),
    .enq_op    (enq_op),
    .deq_valid (deq_valid),
    .deq_op    (deq_op),
    .deq_ready (deq_ready),
    .stat      (q_stat)
  );

  dss_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .deq_valid (deq_valid),
    .deq_op    (deq_op),
    .deq_ready (deq_ready),
    .rsp       (rsp)
  );

  // checks
  `DSS_ASSERT_HOLDS(a_q_state_sane, !(q_stat.full && q_stat.empty), "queue full and empty")
  `DSS_ASSERT_IMPLIES(a_q_full_stalls, q_stat.full, !req.ready, "beat taken into full queue")
  `DSS_ASSERT_IMPLIES(a_empty_rsp, rsp.valid && rsp.status == ST_EMPTY, rsp.read_value == WORD_ONES && (rsp.a_empty || rsp.b_empty), "bad empty response")
  `DSS_ASSERT_IMPLIES(a_overflow_rsp, rsp.valid && rsp.status == ST_OVERFLOW, rsp.read_value == WORD_ZERO && !(rsp.a_empty && rsp.b_empty), "bad overflow response")

endmodule
